/* rtl/bcp_pkg.sv */
// bytecode container parser package: request types, section and error codes, register defaults
package bcp_pkg;

    // section tags carried with each byte
    localparam logic [3:0] SEC_MAGIC      = 4'd0;
    localparam logic [3:0] SEC_VERSION    = 4'd1;
    localparam logic [3:0] SEC_STRCOUNT   = 4'd2;
    localparam logic [3:0] SEC_STRLEN     = 4'd3;
    localparam logic [3:0] SEC_STRBYTE    = 4'd4;
    localparam logic [3:0] SEC_CONSTCOUNT = 4'd5;
    localparam logic [3:0] SEC_KIND       = 4'd6;
    localparam logic [3:0] SEC_PAYLOAD    = 4'd7;
    localparam logic [3:0] SEC_CODELEN    = 4'd8;
    localparam logic [3:0] SEC_CODE       = 4'd9;
    localparam logic [3:0] SEC_IGNORED    = 4'd10;

    // sticky error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_MAGIC   = 3'd1;
    localparam logic [2:0] ERR_VERSION = 3'd2;
    localparam logic [2:0] ERR_KIND    = 3'd3;
    localparam logic [2:0] ERR_INDEX   = 3'd4;
    localparam logic [2:0] ERR_TRUNC   = 3'd5;
    localparam logic [2:0] ERR_TRAIL   = 3'd6;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRING_KIND  = 2'd2;

    // register defaults, magic is "SPBC" little-endian
    localparam logic [31:0] MAGIC_WORD_RST     = 32'h4342_5053;
    localparam logic [7:0]  FORMAT_VERSION_RST = 8'd1;
    localparam logic [7:0]  STRING_KIND_RST    = 8'd0;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       is_last;
    } t_in_req;

    typedef struct packed {
        logic [3:0]  section;
        logic [7:0]  data_byte;
        logic [31:0] position;
        logic [2:0]  error_code;
        logic        file_ok;
        logic        end_of_file;
    } t_out_req;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [7:0]  format_version;
        logic [7:0]  string_const_kind;
    } t_cfg;

endpackage

/* rtl/bcp_in_reg.sv */
// input register stage for incoming byte requests
module bcp_in_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  bcp_pkg::t_in_req i_req,
    input  logic             i_take,
    output logic             o_valid,
    output bcp_pkg::t_in_req o_req
);

    logic             r_valid;
    bcp_pkg::t_in_req r_req;

    // free when empty or when the held request moves on this cycle
    assign o_ready = !r_valid || i_take;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req <= i_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

/* rtl/bcp_parse_core.sv */
// container parse state and the per-byte step that tags each byte
module bcp_parse_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  bcp_pkg::t_in_req  i_req,
    input  bcp_pkg::t_cfg     i_cfg,
    output bcp_pkg::t_out_req o_res
);

    typedef enum logic [3:0] {
        ST_MAGIC      = bcp_pkg::SEC_MAGIC,
        ST_VERSION    = bcp_pkg::SEC_VERSION,
        ST_STRCOUNT   = bcp_pkg::SEC_STRCOUNT,
        ST_STRLEN     = bcp_pkg::SEC_STRLEN,
        ST_STRBYTE    = bcp_pkg::SEC_STRBYTE,
        ST_CONSTCOUNT = bcp_pkg::SEC_CONSTCOUNT,
        ST_KIND       = bcp_pkg::SEC_KIND,
        ST_PAYLOAD    = bcp_pkg::SEC_PAYLOAD,
        ST_CODELEN    = bcp_pkg::SEC_CODELEN,
        ST_CODE       = bcp_pkg::SEC_CODE,
        ST_IGNORED    = bcp_pkg::SEC_IGNORED
    } t_sec_state;

    t_sec_state  r_sec, n_sec;
    logic [1:0]  r_fbc, n_fbc;
    logic [31:0] r_acc, n_acc;
    logic [15:0] r_str_total, n_str_total;
    logic [15:0] r_const_total, n_const_total;
    logic [31:0] r_remain, n_remain;
    logic [31:0] r_item, n_item;
    logic [2:0]  r_err, n_err;

    logic [7:0]  b;
    logic [31:0] acc_col;
    logic [31:0] item_inc;
    logic [31:0] remain_dec;
    logic [15:0] str_index;
    logic [3:0]  sec_out;
    logic [31:0] pos;
    logic [2:0]  err_out;

    assign b          = i_req.byte_value;
    assign acc_col    = r_acc | ({24'd0, b} << {r_fbc, 3'b000});
    assign item_inc   = r_item + 32'd1;
    assign remain_dec = r_remain - 32'd1;
    assign str_index  = {b, r_acc[15:8]};

    // one byte of parsing
    always_comb begin
        n_sec         = r_sec;
        n_fbc         = r_fbc;
        n_acc         = r_acc;
        n_str_total   = r_str_total;
        n_const_total = r_const_total;
        n_remain      = r_remain;
        n_item        = r_item;
        n_err         = r_err;
        sec_out       = bcp_pkg::SEC_IGNORED;
        pos           = 32'd0;

        if (r_err != bcp_pkg::ERR_NONE) begin
            n_sec = ST_IGNORED;
        end else begin
            unique case (r_sec)
                ST_MAGIC: begin
                    sec_out = bcp_pkg::SEC_MAGIC;
                    n_acc   = acc_col;
                    n_fbc   = r_fbc + 2'd1;
                    if (r_fbc == 2'd3) begin
                        n_sec = ST_VERSION;
                    end
                end
                ST_VERSION: begin
                    sec_out = bcp_pkg::SEC_VERSION;
                    if (r_acc != i_cfg.magic_word) begin
                        n_err = bcp_pkg::ERR_MAGIC;
                        n_sec = ST_IGNORED;
                    end else if (b != i_cfg.format_version) begin
                        n_err = bcp_pkg::ERR_VERSION;
                        n_sec = ST_IGNORED;
                    end else begin
                        n_sec = ST_STRCOUNT;
                        n_fbc = 2'd0;
                        n_acc = 32'd0;
                    end
                end
                ST_STRCOUNT: begin
                    sec_out = bcp_pkg::SEC_STRCOUNT;
                    n_acc   = acc_col;
                    n_fbc   = r_fbc + 2'd1;
                    if (r_fbc != 2'd0) begin
                        n_str_total = acc_col[15:0];
                        n_item      = 32'd0;
                        n_fbc       = 2'd0;
                        n_acc       = 32'd0;
                        n_sec       = (acc_col[15:0] == 16'd0) ? ST_CONSTCOUNT : ST_STRLEN;
                    end
                end
                ST_STRLEN: begin
                    sec_out = bcp_pkg::SEC_STRLEN;
                    pos     = r_item;
                    n_acc   = acc_col;
                    n_fbc   = r_fbc + 2'd1;
                    if (r_fbc != 2'd0) begin
                        n_fbc = 2'd0;
                        if (acc_col[15:0] == 16'd0) begin
                            // empty string, move to the next one
                            n_item = item_inc;
                            n_acc  = 32'd0;
                            n_sec  = (item_inc >= {16'd0, r_str_total}) ? ST_CONSTCOUNT
                                                                        : ST_STRLEN;
                        end else begin
                            n_remain = {16'd0, acc_col[15:0]};
                            n_sec    = ST_STRBYTE;
                        end
                    end
                end
                ST_STRBYTE: begin
                    sec_out  = bcp_pkg::SEC_STRBYTE;
                    pos      = r_item;
                    n_remain = remain_dec;
                    if (remain_dec == 32'd0) begin
                        n_item = item_inc;
                        n_fbc  = 2'd0;
                        n_acc  = 32'd0;
                        n_sec  = (item_inc >= {16'd0, r_str_total}) ? ST_CONSTCOUNT
                                                                    : ST_STRLEN;
                    end
                end
                ST_CONSTCOUNT: begin
                    sec_out = bcp_pkg::SEC_CONSTCOUNT;
                    n_acc   = acc_col;
                    n_fbc   = r_fbc + 2'd1;
                    if (r_fbc != 2'd0) begin
                        n_const_total = acc_col[15:0];
                        n_item        = 32'd0;
                        n_fbc         = 2'd0;
                        n_acc         = 32'd0;
                        n_sec         = (acc_col[15:0] == 16'd0) ? ST_CODELEN : ST_KIND;
                    end
                end
                ST_KIND: begin
                    sec_out = bcp_pkg::SEC_KIND;
                    pos     = r_item;
                    n_acc   = {24'd0, b};
                    n_fbc   = 2'd0;
                    n_sec   = ST_PAYLOAD;
                end
                ST_PAYLOAD: begin
                    sec_out = bcp_pkg::SEC_PAYLOAD;
                    pos     = r_item;
                    if (r_fbc == 2'd0) begin
                        n_acc = r_acc | {16'd0, b, 8'd0};
                        n_fbc = 2'd1;
                    end else begin
                        n_fbc = 2'd0;
                        n_acc = r_acc | {8'd0, b, 16'd0};
                        // kind is judged before the string index
                        if (r_acc[7:0] != i_cfg.string_const_kind) begin
                            n_err = bcp_pkg::ERR_KIND;
                            n_sec = ST_IGNORED;
                        end else if (str_index >= r_str_total) begin
                            n_err = bcp_pkg::ERR_INDEX;
                            n_sec = ST_IGNORED;
                        end else begin
                            n_item = item_inc;
                            n_acc  = 32'd0;
                            n_sec  = (item_inc >= {16'd0, r_const_total}) ? ST_CODELEN
                                                                          : ST_KIND;
                        end
                    end
                end
                ST_CODELEN: begin
                    sec_out = bcp_pkg::SEC_CODELEN;
                    n_acc   = acc_col;
                    n_fbc   = r_fbc + 2'd1;
                    if (r_fbc == 2'd3) begin
                        n_remain = acc_col;
                        n_item   = 32'd0;
                        n_sec    = (acc_col == 32'd0) ? ST_IGNORED : ST_CODE;
                    end
                end
                ST_CODE: begin
                    sec_out  = bcp_pkg::SEC_CODE;
                    pos      = r_item;
                    n_item   = item_inc;
                    n_remain = remain_dec;
                    if (remain_dec == 32'd0) begin
                        n_sec = ST_IGNORED;
                    end
                end
                default: begin
                    // byte past a complete layout
                    n_err = bcp_pkg::ERR_TRAIL;
                    n_sec = ST_IGNORED;
                end
            endcase
        end

        // last byte before the layout is complete
        if (i_req.is_last && n_err == bcp_pkg::ERR_NONE && n_sec != ST_IGNORED) begin
            n_err = bcp_pkg::ERR_TRUNC;
        end
        err_out = n_err;

        // restart for the next file
        if (i_req.is_last) begin
            n_sec         = ST_MAGIC;
            n_fbc         = 2'd0;
            n_acc         = 32'd0;
            n_str_total   = 16'd0;
            n_const_total = 16'd0;
            n_remain      = 32'd0;
            n_item        = 32'd0;
            n_err         = bcp_pkg::ERR_NONE;
        end
    end

    // result for this byte
    always_comb begin
        o_res.section     = sec_out;
        o_res.data_byte   = b;
        o_res.position    = pos;
        o_res.error_code  = err_out;
        o_res.file_ok     = i_req.is_last && (err_out == bcp_pkg::ERR_NONE);
        o_res.end_of_file = i_req.is_last;
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec         <= ST_MAGIC;
            r_fbc         <= 2'd0;
            r_acc         <= 32'd0;
            r_str_total   <= 16'd0;
            r_const_total <= 16'd0;
            r_remain      <= 32'd0;
            r_item        <= 32'd0;
            r_err         <= bcp_pkg::ERR_NONE;
        end else if (i_step) begin
            r_sec         <= n_sec;
            r_fbc         <= n_fbc;
            r_acc         <= n_acc;
            r_str_total   <= n_str_total;
            r_const_total <= n_const_total;
            r_remain      <= n_remain;
            r_item        <= n_item;
            r_err         <= n_err;
        end
    end

endmodule

/* rtl/bcp_out_reg.sv */
// result register that holds a tagged byte until it is taken
module bcp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  bcp_pkg::t_out_req i_res,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output bcp_pkg::t_out_req o_res
);

    logic              r_valid;
    bcp_pkg::t_out_req r_res;

    // room for a new result when empty or draining now
    assign o_free = !r_valid || i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* rtl/bytecode_container_parser.sv */
// top level of the bytecode container parser
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_req  (byte, last flag)
//  out     | output    | o_out_valid / i_out_ready  | o_out_req (tagged byte)
//  cfg     | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// one byte per cycle sustained while the output is not stalled; a byte taken into the
// input register is parsed there and moves into the result register once that has room
// reset is synchronous and active low; it restores register defaults and the
// parser to the magic section
// a stalled output holds its result while one more byte waits in the input register
module bytecode_container_parser (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  bcp_pkg::t_in_req                     i_in_req,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output bcp_pkg::t_out_req                    o_out_req,
    input  logic                                 i_cfg_we,
    input  logic [bcp_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [bcp_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    bcp_pkg::t_cfg     r_cfg;
    logic              stage_valid;
    bcp_pkg::t_in_req  stage_req;
    logic              out_free;
    logic              step;
    bcp_pkg::t_out_req step_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_word        <= bcp_pkg::MAGIC_WORD_RST;
            r_cfg.format_version    <= bcp_pkg::FORMAT_VERSION_RST;
            r_cfg.string_const_kind <= bcp_pkg::STRING_KIND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bcp_pkg::CFG_MAGIC_WORD:  r_cfg.magic_word        <= i_cfg_data[31:0];
                bcp_pkg::CFG_VERSION:     r_cfg.format_version    <= i_cfg_data[7:0];
                bcp_pkg::CFG_STRING_KIND: r_cfg.string_const_kind <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // a held request moves on when the result register has room
    assign step = stage_valid && out_free;

    bcp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_req   (i_in_req),
        .i_take  (out_free),
        .o_valid (stage_valid),
        .o_req   (stage_req)
    );

    bcp_parse_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_req   (stage_req),
        .i_cfg   (r_cfg),
        .o_res   (step_res)
    );

    bcp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step),
        .i_res   (step_res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (o_out_req)
    );

endmodule

/* rtl/bcp_checker.sv */
// port-level checks for the bytecode container parser, bound to the top level
module bcp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input bcp_pkg::t_out_req              o_out_req
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_req))
        else $error("result changed while stalled");

    // input only backs up when the output is stalled
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output back-pressure");

    // file_ok only on a clean last byte
    a_file_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.file_ok |->
            o_out_req.end_of_file && o_out_req.error_code == bcp_pkg::ERR_NONE)
        else $error("file_ok without a clean end of file");

    // truncation is reported on the last byte only
    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.error_code == bcp_pkg::ERR_TRUNC |->
            o_out_req.end_of_file)
        else $error("truncation reported before the last byte");

endmodule

bind bytecode_container_parser bcp_checker u_bcp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_req   (o_out_req)
);
